/* src/pinhole_point_projection_assert.svh */
// Assertion macros used by the checker file.
`ifndef PINHOLE_POINT_PROJECTION_ASSERT_SVH
`define PINHOLE_POINT_PROJECTION_ASSERT_SVH

// Concurrent check, skipped while the reset is active.
`define PPP_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define PPP_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ppp_pkg.sv */
package ppp_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FIELD_W = 32;
   localparam int PROD_W  = 64;
   // quotient bits kept below the overflow bound (bound is 2^34)
   localparam int DIV_BITS = 35;
   localparam int DIV_LAT  = DIV_BITS + 1;
   // input reg, products, row sums, camera point, focal products,
   // divider, output reg
   localparam int PIPE_DEPTH = 5 + DIV_LAT + 1;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_FOCAL  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CX     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CY     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIENT = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TX     = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TY     = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TZ     = 8'd6;

   typedef struct packed {
      logic signed [FIELD_W-1:0] point_x;
      logic signed [FIELD_W-1:0] point_y;
      logic signed [FIELD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] pixel_u;
      logic signed [FIELD_W-1:0] pixel_v;
      logic signed [FIELD_W-1:0] depth;
      logic                      invalid;
   } rsp_type;

   typedef struct packed {
      logic [PROD_W-1:0]  dividend;
      logic [FIELD_W-1:0] divisor;
   } div_in_type;

   typedef struct packed {
      logic [DIV_BITS-1:0] quotient;
      logic                ovf;
   } div_out_type;

endpackage

/* src/ppp_div.sv */
module ppp_div (
   input  logic                clock,
   input  ppp_pkg::div_in_type div_in,
   output ppp_pkg::div_out_type div_out
);

   localparam int NB = ppp_pkg::DIV_BITS;
   localparam int DW = ppp_pkg::FIELD_W;

   logic [DW-1:0] rem_ff [0:NB];
   logic [NB-1:0] low_ff [0:NB];
   logic [NB-1:0] quo_ff [0:NB];
   logic [DW-1:0] den_ff [0:NB];
   logic          ovf_ff [0:NB];

   // high part of the dividend at least the divisor: quotient too large
   always_ff @(posedge clock) begin
      rem_ff[0] <= DW'(div_in.dividend[ppp_pkg::PROD_W-1:NB]);
      low_ff[0] <= div_in.dividend[NB-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= div_in.divisor;
      ovf_ff[0] <= DW'(div_in.dividend[ppp_pkg::PROD_W-1:NB]) >= div_in.divisor;
   end

   for (genvar k = 1; k <= NB; k++) begin : g_step
      logic [DW:0] trial_in;
      logic        take_in;
      always_comb begin
         trial_in = {rem_ff[k-1], low_ff[k-1][NB-k]};
         take_in  = trial_in >= {1'b0, den_ff[k-1]};
      end
      always_ff @(posedge clock) begin
         rem_ff[k] <= take_in ? DW'(trial_in - {1'b0, den_ff[k-1]}) : DW'(trial_in);
         quo_ff[k] <= {quo_ff[k-1][NB-2:0], take_in};
         low_ff[k] <= low_ff[k-1];
         den_ff[k] <= den_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
      end
   end

   assign div_out.quotient = quo_ff[NB];
   assign div_out.ovf      = ovf_ff[NB];

endmodule

/* src/pinhole_point_projection.sv */
// Pinhole projection of one Q16.16 world point per cycle: rotation by the
// configured quaternion, translation, then u = f*xc/zc + cx, v = f*yc/zc + cy.
// A point is taken in every cycle in which start is high and busy is low; busy
// is high only during reset. Each result appears on rsp_result for one cycle
// with rsp_valid, in input order, behind the bit-per-stage dividers (one
// quotient bit per stage, 35 bits). Results cannot be held off, so the
// receiver must take each one. Configuration writes are taken in every cycle
// and must be done with the pipeline empty; the rotation matrix follows the
// orientation register through the registered quaternion products and the
// registered matrix entries.
module pinhole_point_projection #(
   parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ppp_pkg::req_type                    req_point,
   output logic                                rsp_valid,
   output ppp_pkg::rsp_type                    rsp_result,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int CW_EFF = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int FW = ppp_pkg::FIELD_W;
   localparam int NB = ppp_pkg::DIV_BITS;
   localparam int DL = ppp_pkg::DIV_LAT;

   localparam logic signed [41:0] CAM_MAX = (42'sd1 <<< (CW_EFF - 1)) - 42'sd1;
   localparam logic signed [41:0] CAM_MIN = -(42'sd1 <<< (CW_EFF - 1));
   localparam logic signed [36:0] PIX_MAX = (37'sd1 <<< (CW_EFF - 1)) - 37'sd1;
   localparam logic signed [36:0] PIX_MIN = -(37'sd1 <<< (CW_EFF - 1));
   localparam logic [NB-1:0] Q_BOUND = NB'(1) << (NB - 1);
   localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

   typedef struct packed {
      logic              zero;
      logic              neg_num_u;
      logic              neg_num_v;
      logic              neg_u;
      logic              neg_v;
      logic signed [FW-1:0] depth;
   } side_type;

   // configuration registers
   logic [FW-1:0] focal_ff;
   logic signed [FW-1:0] cx_ff, cy_ff, tx_ff, ty_ff, tz_ff;
   logic [63:0] orient_ff;

   assign csr_ready = 1'b1;
   assign busy      = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff  <= 32'd65536;
         cx_ff     <= '0;
         cy_ff     <= '0;
         orient_ff <= 64'd16384;
         tx_ff     <= '0;
         ty_ff     <= '0;
         tz_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ppp_pkg::CSR_FOCAL:  focal_ff  <= csr_data[FW-1:0];
            ppp_pkg::CSR_CX:     cx_ff     <= csr_data[FW-1:0];
            ppp_pkg::CSR_CY:     cy_ff     <= csr_data[FW-1:0];
            ppp_pkg::CSR_ORIENT: orient_ff <= csr_data;
            ppp_pkg::CSR_TX:     tx_ff     <= csr_data[FW-1:0];
            ppp_pkg::CSR_TY:     ty_ff     <= csr_data[FW-1:0];
            ppp_pkg::CSR_TZ:     tz_ff     <= csr_data[FW-1:0];
            default: ;
         endcase
      end
   end

   // rotation matrix, rebuilt continuously from the orientation register
   logic signed [15:0] qw, qx, qy, qz;
   logic signed [31:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [34:0] ent_in [0:8];
   logic signed [26:0] ent_ff [0:8];

   assign qw = orient_ff[15:0];
   assign qx = orient_ff[31:16];
   assign qy = orient_ff[47:32];
   assign qz = orient_ff[63:48];

   always_ff @(posedge clock) begin
      xx_ff <= qx * qx;
      yy_ff <= qy * qy;
      zz_ff <= qz * qz;
      xy_ff <= qx * qy;
      xz_ff <= qx * qz;
      yz_ff <= qy * qz;
      wx_ff <= qw * qx;
      wy_ff <= qw * qy;
      wz_ff <= qw * qz;
   end

   always_comb begin
      ent_in[0] = ONE_Q28 - ((35'(yy_ff) + 35'(zz_ff)) <<< 1);
      ent_in[1] = (35'(xy_ff) - 35'(wz_ff)) <<< 1;
      ent_in[2] = (35'(xz_ff) + 35'(wy_ff)) <<< 1;
      ent_in[3] = (35'(xy_ff) + 35'(wz_ff)) <<< 1;
      ent_in[4] = ONE_Q28 - ((35'(xx_ff) + 35'(zz_ff)) <<< 1);
      ent_in[5] = (35'(yz_ff) - 35'(wx_ff)) <<< 1;
      ent_in[6] = (35'(xz_ff) - 35'(wy_ff)) <<< 1;
      ent_in[7] = (35'(yz_ff) + 35'(wx_ff)) <<< 1;
      ent_in[8] = ONE_Q28 - ((35'(xx_ff) + 35'(yy_ff)) <<< 1);
   end

   for (genvar e = 0; e < 9; e++) begin : g_ent
      logic signed [34:0] rnd_in;
      assign rnd_in = (ent_in[e] + 35'sd128) >>> 8;
      always_ff @(posedge clock) begin
         ent_ff[e] <= rnd_in[26:0];
      end
   end

   // stage 0: capture point
   logic [ppp_pkg::PIPE_DEPTH-2:0] vld_ff;
   logic signed [FW-1:0] pt_ff [0:2];
   logic signed [CW_EFF-1:0] pt_cut_in [0:2];

   always_comb begin
      pt_cut_in[0] = req_point.point_x[CW_EFF-1:0];
      pt_cut_in[1] = req_point.point_y[CW_EFF-1:0];
      pt_cut_in[2] = req_point.point_z[CW_EFF-1:0];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) pt_ff[i] <= FW'(pt_cut_in[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ppp_pkg::PIPE_DEPTH-3:0], start && !busy};
      end
   end

   // stage 1: matrix times point
   logic signed [58:0] mul_ff [0:8];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) mul_ff[i] <= ent_ff[i] * pt_ff[i % 3];
   end

   // stage 2: row sums
   logic signed [60:0] acc_ff [0:2];
   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         acc_ff[r] <= 61'(mul_ff[3*r]) + 61'(mul_ff[3*r+1]) + 61'(mul_ff[3*r+2]);
      end
   end

   // stage 3: round to Q16.16, translate, saturate
   logic signed [FW-1:0] tr [0:2];
   logic signed [FW-1:0] cam_ff [0:2];
   assign tr[0] = tx_ff;
   assign tr[1] = ty_ff;
   assign tr[2] = tz_ff;

   for (genvar r = 0; r < 3; r++) begin : g_cam
      logic signed [60:0] sh_in;
      logic signed [41:0] sum_in;
      always_comb begin
         sh_in  = (acc_ff[r] + 61'sd524288) >>> 20;
         sum_in = 42'($signed(sh_in[40:0])) + 42'(tr[r]);
      end
      always_ff @(posedge clock) begin
         priority if (sum_in > CAM_MAX) cam_ff[r] <= FW'(CAM_MAX);
         else if (sum_in < CAM_MIN)     cam_ff[r] <= FW'(CAM_MIN);
         else                           cam_ff[r] <= FW'(sum_in);
      end
   end

   // stage 4: focal products and signs
   ppp_pkg::div_in_type div_u_ff, div_v_ff;
   side_type side_in;
   logic [FW-1:0] mag_u, mag_v, mag_z;

   always_comb begin
      mag_u = cam_ff[0][FW-1] ? FW'(-cam_ff[0]) : FW'(cam_ff[0]);
      mag_v = cam_ff[1][FW-1] ? FW'(-cam_ff[1]) : FW'(cam_ff[1]);
      mag_z = cam_ff[2][FW-1] ? FW'(-cam_ff[2]) : FW'(cam_ff[2]);
      side_in.zero      = (cam_ff[2] == '0);
      side_in.neg_num_u = cam_ff[0][FW-1] && (focal_ff != '0);
      side_in.neg_num_v = cam_ff[1][FW-1] && (focal_ff != '0);
      side_in.neg_u     = side_in.neg_num_u != cam_ff[2][FW-1];
      side_in.neg_v     = side_in.neg_num_v != cam_ff[2][FW-1];
      side_in.depth     = cam_ff[2];
   end

   side_type side_ff [0:DL];
   always_ff @(posedge clock) begin
      div_u_ff.dividend <= 64'(focal_ff) * 64'(mag_u);
      div_v_ff.dividend <= 64'(focal_ff) * 64'(mag_v);
      div_u_ff.divisor  <= mag_z;
      div_v_ff.divisor  <= mag_z;
      side_ff[0]        <= side_in;
      for (int k = 1; k <= DL; k++) side_ff[k] <= side_ff[k-1];
   end

   ppp_pkg::div_out_type quo_u, quo_v;

   ppp_div u_div_u (.clock(clock), .div_in(div_u_ff), .div_out(quo_u));
   ppp_div u_div_v (.clock(clock), .div_in(div_v_ff), .div_out(quo_v));

   // final: sign, principal point, saturation
   side_type sd;
   logic signed [36:0] su_in, sv_in;
   logic signed [FW-1:0] u_in, v_in;
   logic bad_u_in, bad_v_in;

   assign sd = side_ff[DL];

   always_comb begin
      su_in = (sd.neg_u ? -37'(quo_u.quotient) : 37'(quo_u.quotient)) + 37'(cx_ff);
      sv_in = (sd.neg_v ? -37'(quo_v.quotient) : 37'(quo_v.quotient)) + 37'(cy_ff);

      bad_u_in = 1'b1;
      priority if (sd.zero) begin
         u_in = sd.neg_num_u ? FW'(PIX_MIN) : FW'(PIX_MAX);
      end else if (quo_u.ovf || quo_u.quotient > Q_BOUND) begin
         u_in = sd.neg_u ? FW'(PIX_MIN) : FW'(PIX_MAX);
      end else if (su_in > PIX_MAX) begin
         u_in = FW'(PIX_MAX);
      end else if (su_in < PIX_MIN) begin
         u_in = FW'(PIX_MIN);
      end else begin
         u_in = FW'(su_in);
         bad_u_in = 1'b0;
      end

      bad_v_in = 1'b1;
      priority if (sd.zero) begin
         v_in = sd.neg_num_v ? FW'(PIX_MIN) : FW'(PIX_MAX);
      end else if (quo_v.ovf || quo_v.quotient > Q_BOUND) begin
         v_in = sd.neg_v ? FW'(PIX_MIN) : FW'(PIX_MAX);
      end else if (sv_in > PIX_MAX) begin
         v_in = FW'(PIX_MAX);
      end else if (sv_in < PIX_MIN) begin
         v_in = FW'(PIX_MIN);
      end else begin
         v_in = FW'(sv_in);
         bad_v_in = 1'b0;
      end
   end

   ppp_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      rsp_ff.pixel_u <= u_in;
      rsp_ff.pixel_v <= v_in;
      rsp_ff.depth   <= sd.depth;
      rsp_ff.invalid <= bad_u_in || bad_v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[ppp_pkg::PIPE_DEPTH-2];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

/* src/ppp_checker.sv */
`include "pinhole_point_projection_assert.svh"

module ppp_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input ppp_pkg::rsp_type rsp_result
);

   // every result traces back to a point taken a fixed latency earlier
   `PPP_ASSERT_RST(a_rsp_has_req, clock, reset, rsp_valid |-> $past(start && !busy, ppp_pkg::PIPE_DEPTH), "result without a matching transaction")

   // zero depth always flags the result
   `PPP_ASSERT_RST(a_zero_depth_flag, clock, reset, (rsp_valid && rsp_result.depth == '0) |-> rsp_result.invalid, "zero depth not flagged invalid")

   // reset empties the output
   `PPP_ASSERT_ALL(a_reset_clears, clock, reset |=> !rsp_valid, "result strobe after reset")

endmodule

bind pinhole_point_projection ppp_checker u_ppp_checker (.*);
